FILE: hdl/aclr_pkg.sv
// Package for the ACL packet reassembler: field widths, codes and the result type.
`default_nettype none

package aclr_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 12;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ErrW   = 32;

  // Packet header layout: bytes 2 and 3 carry the little-endian payload length
  localparam logic [CountW-1:0] HdrLenLoPos = 12'd2;
  localparam logic [CountW-1:0] HdrLenHiPos = 12'd3;
  localparam logic [CountW-1:0] HdrFirstPos = 12'd0;
  localparam logic [LenW:0]     HeaderBytes = 17'd4;
  // Largest payload length whose packet length still fits in 16 bits
  localparam logic [LenW-1:0]   MaxPayload  = 16'hFFFB;

  // Input action codes
  typedef enum logic {
    ACT_DATA       = 1'b0,
    ACT_LINK_RESET = 1'b1
  } action_e;

  // Result kinds
  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_ABORT = 1'b1
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  out_byte;
    logic              packet_first;
    logic              packet_last;
    logic [ErrW-1:0]   overflow_errors;
  } res_t;

  // Result handed from the parser to the output stage
  typedef struct packed {
    logic vld;
    res_t res;
  } res_req_t;

endpackage

`default_nettype wire

FILE: hdl/aclr_if.sv
// Valid/ready channel interfaces for the reassembler's input bytes and results.
`default_nettype none

interface aclr_in_if;
  import aclr_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [ByteW-1:0]    byte_value;
  logic                chunk_first;
  logic [CountW-1:0]   chunk_length;

  modport source (
    output valid, action, byte_value, chunk_first, chunk_length,
    input  ready
  );
  modport sink (
    input  valid, action, byte_value, chunk_first, chunk_length,
    output ready
  );
endinterface

interface aclr_out_if;
  import aclr_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [ByteW-1:0]    out_byte;
  logic                packet_first;
  logic                packet_last;
  logic [ErrW-1:0]     overflow_errors;

  modport source (
    output valid, kind, out_byte, packet_first, packet_last, overflow_errors,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, packet_first, packet_last, overflow_errors,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/aclr_parser.sv
// Per-byte parser: chunk and packet counters, overflow checks, result generation.
`default_nettype none

module aclr_parser #(
  parameter int unsigned BUFFER_BYTES = 2048
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          take_i,
  input  wire logic                          action_i,
  input  wire logic [aclr_pkg::ByteW-1:0]    byte_value_i,
  input  wire logic                          chunk_first_i,
  input  wire logic [aclr_pkg::CountW-1:0]   chunk_length_i,
  output aclr_pkg::res_req_t                 res_o
);
  import aclr_pkg::*;

  localparam logic [CountW:0] BufLimit = (CountW+1)'(BUFFER_BYTES);

  logic [CountW-1:0] held_q, held_d;
  logic [ByteW-1:0]  len_lo_q, len_lo_d;
  logic [LenW-1:0]   plen_q, plen_d;
  logic [CountW-1:0] skip_q, skip_d;
  logic [CountW-1:0] left_q, left_d;
  logic [ErrW-1:0]   err_q, err_d;

  logic [CountW-1:0] clen_eff;
  logic [CountW-1:0] left_src;
  logic [CountW-1:0] left_nxt;
  logic [LenW-1:0]   plen_cur;
  logic              go;

  // Next state and result for one request
  always_comb begin
    held_d   = held_q;
    len_lo_d = len_lo_q;
    plen_d   = plen_q;
    skip_d   = skip_q;
    left_d   = left_q;
    err_d    = err_q;
    go       = 1'b0;
    clen_eff = (chunk_length_i == '0) ? CountW'(1) : chunk_length_i;
    left_src = chunk_first_i ? clen_eff : left_q;
    left_nxt = left_src - CountW'(1);
    plen_cur = (held_q == HdrLenHiPos) ? {byte_value_i, len_lo_q} : plen_q;

    res_o.vld                 = 1'b0;
    res_o.res.kind            = KIND_ABORT;
    res_o.res.out_byte        = '0;
    res_o.res.packet_first    = 1'b0;
    res_o.res.packet_last     = 1'b0;

    if (action_i == ACT_LINK_RESET) begin
      // Link reset drops the partial packet and any open chunk
      held_d    = '0;
      skip_d    = '0;
      left_d    = '0;
      res_o.vld = (held_q != '0);
    end else if (chunk_first_i) begin
      skip_d = '0;
      left_d = '0;
      if (({1'b0, held_q} + {1'b0, clen_eff}) > BufLimit) begin
        // Chunk does not fit: discard it whole
        err_d     = err_q + ErrW'(1);
        held_d    = '0;
        skip_d    = clen_eff - CountW'(1);
        res_o.vld = (held_q != '0);
      end else begin
        go = 1'b1;
      end
    end else if (skip_q != '0) begin
      skip_d = skip_q - CountW'(1);
    end else if (left_q != '0) begin
      go = 1'b1;
    end

    // Forward a byte of an open chunk
    if (go) begin
      left_d = left_nxt;
      if (held_q == HdrLenLoPos) begin
        len_lo_d = byte_value_i;
      end
      if (held_q == HdrLenHiPos) begin
        plen_d = plen_cur;
      end
      if (held_q == HdrLenHiPos && plen_cur > MaxPayload) begin
        // Packet length would wrap 16 bits
        err_d     = err_q + ErrW'(1);
        held_d    = '0;
        skip_d    = left_nxt;
        left_d    = '0;
        res_o.vld = 1'b1;
      end else begin
        res_o.vld              = 1'b1;
        res_o.res.kind         = KIND_DATA;
        res_o.res.out_byte     = byte_value_i;
        res_o.res.packet_first = (held_q == HdrFirstPos);
        if (held_q >= HdrLenHiPos &&
            ({5'd0, held_q} + 17'd1) == (HeaderBytes + {1'b0, plen_cur})) begin
          held_d                = '0;
          res_o.res.packet_last = 1'b1;
        end else begin
          held_d = held_q + CountW'(1);
        end
      end
    end

    res_o.res.overflow_errors = err_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      len_lo_q <= '0;
      plen_q   <= '0;
      skip_q   <= '0;
      left_q   <= '0;
      err_q    <= '0;
    end else if (take_i) begin
      held_q   <= held_d;
      len_lo_q <= len_lo_d;
      plen_q   <= plen_d;
      skip_q   <= skip_d;
      left_q   <= left_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/aclr_out_stage.sv
// Output register: holds one result request until the sink takes it.
`default_nettype none

module aclr_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                take_i,
  input  wire aclr_pkg::res_req_t  res_i,
  output logic                     space_o,
  aclr_out_if.source               out_o
);
  import aclr_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Room for a new result when empty or draining this cycle
  assign space_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (take_i && res_i.vld) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (take_i && res_i.vld) begin
      res_q <= res_i.res;
    end
  end

  assign out_o.valid           = valid_q;
  assign out_o.kind            = res_q.kind;
  assign out_o.out_byte        = res_q.out_byte;
  assign out_o.packet_first    = res_q.packet_first;
  assign out_o.packet_last     = res_q.packet_last;
  assign out_o.overflow_errors = res_q.overflow_errors;

endmodule

`default_nettype wire

FILE: hdl/acl_packet_reassembler.sv
// Top level of the cut-through ACL packet reassembler.
//
// Takes one chunked byte per cycle and forwards it at once, marked with packet
// first/last, or emits an abort when a chunk overflows the BUFFER_BYTES
// partial-packet budget while a partial packet is held, a header's payload
// length would wrap 16 bits, or a link reset hits a partial packet. For each
// request the parser updates its counters and writes at most one result into
// a single output register, so a new byte is taken each cycle whenever that
// register is empty or being drained. Each result is valid in the next cycle.
// overflow_errors carries the running discard count after each result's update.
`default_nettype none

module acl_packet_reassembler #(
  parameter int unsigned BUFFER_BYTES = 2048
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  aclr_in_if.sink     in_i,
  aclr_out_if.source  out_o
);
  import aclr_pkg::*;

  logic     space;
  logic     take;
  res_req_t res_req;

  assign in_i.ready = space;
  assign take       = in_i.valid && space;

  aclr_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .action_i       (in_i.action),
    .byte_value_i   (in_i.byte_value),
    .chunk_first_i  (in_i.chunk_first),
    .chunk_length_i (in_i.chunk_length),
    .res_o          (res_req)
  );

  aclr_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .res_i   (res_req),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

FILE: verif/acl_packet_reassembler_tb.sv
// Self-checking testbench for acl_packet_reassembler: chunked byte stimulus, scoreboard check.
module acl_packet_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aclr_pkg::*;

  localparam int unsigned BufferBytes = 2048;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 900;
  localparam int unsigned ShowLimit   = 10;

  // One input request as the block sees it
  typedef struct packed {
    action_e           action;
    logic [ByteW-1:0]  byte_value;
    logic              chunk_first;
    logic [CountW-1:0] chunk_length;
  } byte_req_t;

  typedef logic [ByteW-1:0] byte_q_t[$];

  // Tracks the parser state and holds the results each request should cause
  class reassembly_checker;
    logic [CountW-1:0] held_bytes;
    logic [CountW-1:0] skip_left;
    logic [CountW-1:0] chunk_open;
    logic [ByteW-1:0]  len_lo;
    logic [LenW-1:0]   pay_len;
    logic [ErrW-1:0]   overflow_total;
    res_t              awaited[$];
    int unsigned       failures;

    function new();
      held_bytes     = '0;
      skip_left      = '0;
      chunk_open     = '0;
      len_lo         = '0;
      pay_len        = '0;
      overflow_total = '0;
      failures       = 0;
    endfunction

    function void push_result(kind_e kind, logic [ByteW-1:0] b, logic first, logic last);
      res_t r;
      r.kind            = kind;
      r.out_byte        = b;
      r.packet_first    = first;
      r.packet_last     = last;
      r.overflow_errors = overflow_total;
      awaited.push_back(r);
    endfunction

    // Note an accepted request and predict its result, if any
    function void take_request(byte_req_t req);
      int unsigned clen;
      int unsigned pos;
      bit          had;
      if (req.action == ACT_LINK_RESET) begin
        had        = held_bytes != 0;
        held_bytes = '0;
        skip_left  = '0;
        chunk_open = '0;
        if (had) push_result(KIND_ABORT, '0, 1'b0, 1'b0);
        return;
      end
      if (req.chunk_first) begin
        clen       = (req.chunk_length == 0) ? 1 : 32'(req.chunk_length);
        skip_left  = '0;
        chunk_open = '0;
        // chunk would not fit beside the held partial packet: drop it whole
        if (held_bytes + clen > BufferBytes) begin
          had            = held_bytes != 0;
          overflow_total = overflow_total + 1;
          held_bytes     = '0;
          skip_left      = CountW'(clen - 1);
          if (had) push_result(KIND_ABORT, '0, 1'b0, 1'b0);
          return;
        end
        chunk_open = CountW'(clen);
      end else if (skip_left != 0) begin
        skip_left = skip_left - CountW'(1);
        return;
      end else if (chunk_open == 0) begin
        return;
      end
      chunk_open = chunk_open - CountW'(1);
      pos        = 32'(held_bytes);
      if (pos == HdrLenLoPos) len_lo = req.byte_value;
      if (pos == HdrLenHiPos) begin
        pay_len = {req.byte_value, len_lo};
        // total length would wrap 16 bits
        if (pay_len > MaxPayload) begin
          overflow_total = overflow_total + 1;
          held_bytes     = '0;
          skip_left      = chunk_open;
          chunk_open     = '0;
          push_result(KIND_ABORT, '0, 1'b0, 1'b0);
          return;
        end
      end
      if (pos >= HdrLenHiPos && pos + 1 == HeaderBytes + pay_len) begin
        held_bytes = '0;
        push_result(KIND_DATA, req.byte_value, pos == HdrFirstPos, 1'b1);
        return;
      end
      held_bytes = CountW'(pos + 1);
      push_result(KIND_DATA, req.byte_value, pos == HdrFirstPos, 1'b0);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= ShowLimit)
          $display({"%0t: result with nothing awaited: kind %0d byte %02h first %0b",
                    " last %0b errors %0d"},
                   $realtime, got.kind, got.out_byte, got.packet_first, got.packet_last,
                   got.overflow_errors);
        return;
      end
      want = awaited.pop_front();
      if (got.kind != want.kind || got.out_byte != want.out_byte ||
          got.packet_first != want.packet_first || got.packet_last != want.packet_last ||
          got.overflow_errors != want.overflow_errors) begin
        failures++;
        if (failures <= ShowLimit)
          $display({"%0t: mismatch: expected kind %0d byte %02h first %0b last %0b errors %0d,",
                    " got kind %0d byte %02h first %0b last %0b errors %0d"},
                   $realtime, want.kind, want.out_byte, want.packet_first, want.packet_last,
                   want.overflow_errors, got.kind, got.out_byte, got.packet_first,
                   got.packet_last, got.overflow_errors);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  aclr_in_if  in_bus ();
  aclr_out_if out_bus ();

  acl_packet_reassembler #(
    .BUFFER_BYTES(BufferBytes)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  reassembly_checker sb;
  bit                send_burst;
  bit                recv_burst;
  int unsigned       sent_items;
  int unsigned       cycles_run;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Gap before the next request; occasionally switch into or out of a no-gap stretch
  function automatic int unsigned draw_gap(ref bit burst);
    if ($urandom_range(0, 39) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // Drive one request and wait for it to be taken
  task automatic send_request(action_e act, logic [ByteW-1:0] b, logic cf,
                              logic [CountW-1:0] cl);
    int unsigned gap;
    byte_req_t   req;
    req.action       = act;
    req.byte_value   = b;
    req.chunk_first  = cf;
    req.chunk_length = cl;
    gap = draw_gap(send_burst);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.action       <= act;
    in_bus.byte_value   <= b;
    in_bus.chunk_first  <= cf;
    in_bus.chunk_length <= cl;
    do @(posedge clk); while (!in_bus.ready);
    sb.take_request(req);
    sent_items++;
  endtask

  // One chunk: the first byte carries the declared length, the rest carry noise there
  task automatic send_chunk(byte_q_t data, logic [CountW-1:0] declared);
    foreach (data[i])
      send_request(ACT_DATA, data[i], i == 0, (i == 0) ? declared : CountW'($urandom));
  endtask

  // Split a byte stream into well-formed chunks of random size
  task automatic send_stream(byte_q_t data, int unsigned max_chunk);
    int unsigned at;
    int unsigned n;
    at = 0;
    while (at < data.size()) begin
      n = $urandom_range(1, max_chunk);
      if (at + n > data.size()) n = data.size() - at;
      send_chunk(data[at:at+n-1], CountW'(n));
      at += n;
    end
  endtask

  function automatic byte_q_t make_packet(logic [LenW-1:0] plen, int unsigned body);
    byte_q_t pkt;
    pkt.push_back(ByteW'($urandom));
    pkt.push_back(ByteW'($urandom));
    pkt.push_back(plen[7:0]);
    pkt.push_back(plen[15:8]);
    repeat (body) pkt.push_back(ByteW'($urandom));
    return pkt;
  endfunction

  // Stop sending until every predicted result has come out
  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
  endtask

  // Result side: random stalls, check every accepted result
  initial begin : result_sink
    int unsigned gap;
    res_t        got;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap(recv_burst);
      if (gap != 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      got.kind            = kind_e'(out_bus.kind);
      got.out_byte        = out_bus.out_byte;
      got.packet_first    = out_bus.packet_first;
      got.packet_last     = out_bus.packet_last;
      got.overflow_errors = out_bus.overflow_errors;
      sb.check_result(got);
    end
  end

  // Stimulus
  initial begin : byte_source
    byte_q_t     pkt;
    int unsigned pick;
    int unsigned plen;
    int unsigned cut;
    int unsigned need;
    bit          paused;
    sb                  = new();
    sent_items          = 0;
    send_burst          = 1'b0;
    recv_burst          = 1'b0;
    paused              = 1'b0;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_DATA;
    in_bus.byte_value   = '0;
    in_bus.chunk_first  = 1'b0;
    in_bus.chunk_length = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty payload, last mark on header byte 3
    send_chunk({8'h00, 8'hFF, 8'h00, 8'h00}, 12'd4);
    // Zero chunk length taken as one byte, then the rest of a one-byte payload
    send_chunk({8'hAA}, 12'd0);
    send_chunk({8'h55, 8'h01, 8'h00, 8'h7E}, 12'd4);
    // Stray byte with no chunk open
    send_request(ACT_DATA, 8'hC3, 1'b0, 12'hFFF);
    // Link reset with nothing held
    send_request(ACT_LINK_RESET, 8'h5A, 1'b0, 12'h800);
    // Payload length wraps 16 bits: abort, rest of chunk dropped
    send_chunk({8'h01, 8'h02, 8'hFF, 8'hFF, 8'h33, 8'h44}, 12'd6);
    // Oversized chunk with nothing held: count only, then a dropped byte
    send_chunk({8'hFF, 8'h00}, 12'd4095);
    // Partial packet, then a chunk one byte past the budget
    send_chunk({8'h10, 8'h20}, 12'd2);
    send_request(ACT_DATA, 8'h99, 1'b1, 12'd2047);
    // Chunk exactly at the budget, abandoned by a link reset
    send_request(ACT_DATA, 8'h81, 1'b1, 12'd2048);
    send_request(ACT_LINK_RESET, 8'h00, 1'b1, 12'd0);
    hold_until_drained();

    // Random: mostly well-formed packets, with broken chunks and resets mixed in
    sent_items = 0;
    while (sent_items < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        send_stream(make_packet(LenW'(plen), plen),
                    ($urandom_range(0, 3) == 0) ? plen + 4 : $urandom_range(1, 12));
      end else if (pick < 70) begin
        // header whose length wraps, with trailing bytes in the same stream
        pkt = make_packet(LenW'($urandom_range(16'hFFFC, 16'hFFFF)), $urandom_range(0, 6));
        send_stream(pkt, $urandom_range(1, 10));
      end else if (pick < 79) begin
        // oversized or exactly fitting chunk, often on top of a partial packet
        if ($urandom_range(0, 1) == 1) begin
          plen = $urandom_range(1, 40);
          pkt  = make_packet(LenW'(plen), plen);
          cut  = $urandom_range(1, plen + 3);
          send_stream(pkt[0:cut-1], $urandom_range(1, 8));
        end
        case ($urandom_range(0, 2))
          0: need = BufferBytes + 1 - sb.held_bytes;
          1: need = BufferBytes - sb.held_bytes;
          default: need = $urandom_range(BufferBytes + 1, 4095);
        endcase
        send_request(ACT_DATA, ByteW'($urandom), 1'b1, CountW'(need));
        repeat ($urandom_range(0, 5))
          send_request(ACT_DATA, ByteW'($urandom), 1'b0, CountW'($urandom));
      end else if (pick < 86) begin
        // link reset, often cutting a packet short
        if ($urandom_range(0, 2) != 0) begin
          plen = $urandom_range(0, 30);
          pkt  = make_packet(LenW'(plen), plen);
          cut  = $urandom_range(1, plen + 3);
          send_stream(pkt[0:cut-1], $urandom_range(1, 8));
        end
        send_request(ACT_LINK_RESET, ByteW'($urandom), 1'($urandom), CountW'($urandom));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4))
          send_request(ACT_DATA, ByteW'($urandom), 1'b0, CountW'($urandom));
      end else begin
        // declared length drawn independently of the bytes that follow
        pkt.delete();
        repeat ($urandom_range(1, 16)) pkt.push_back(ByteW'($urandom));
        send_chunk(pkt, CountW'($urandom_range(0, 15)));
      end
      if (!paused && sent_items >= RandomBytes / 2) begin
        paused = 1'b1;
        hold_until_drained();
      end
    end

    // Drain and let the pipeline settle
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0);
    repeat (4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
